>>> rtl/core/msde_pkg.sv
// ----------------------------------------------------------------------------
// msde_pkg
// Shared types, instruction kind codes and control tables for the decoder.
// ----------------------------------------------------------------------------
package msde_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned REG_ADDR_BITS = 5;
    localparam logic [WORD_BITS-1:0] RESET_PC = 32'd256;

    // instruction kinds
    typedef enum logic [4:0] {
        K_ADD = 5'd0, K_SUB = 5'd1, K_AND = 5'd2, K_OR = 5'd3, K_NOR = 5'd4,
        K_SLT = 5'd5, K_SLL = 5'd6, K_SRL = 5'd7, K_MULT = 5'd8, K_MUL = 5'd9,
        K_DIV = 5'd10, K_JR = 5'd11, K_J = 5'd12, K_JAL = 5'd13, K_ADDI = 5'd14,
        K_LW = 5'd15, K_SW = 5'd16, K_BEQ = 5'd17, K_BNE = 5'd18,
        K_UNKNOWN = 5'd19
    } kind_t;

    // opcodes and function codes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_SPEC2 = 6'h1C;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_MUL   = 6'h02;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;

    // decoded instruction handed to the execute unit
    typedef struct packed {
        kind_t                    kind;
        logic [REG_ADDR_BITS-1:0] rs;
        logic [REG_ADDR_BITS-1:0] rt;
        logic [REG_ADDR_BITS-1:0] rd;
        logic [4:0]               shamt;
        logic [WORD_BITS-1:0]     imm;
        logic [25:0]              target;
    } decoded_t;

    // control table per kind
    function automatic logic [7:0] ctl_bits(input kind_t k);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            K_ADD, K_AND, K_OR, K_NOR, K_SLT, K_MUL: c = 8'h03;
            K_SUB, K_SRL: c = 8'h07;
            K_SLL, K_ADDI: c = 8'h06;
            K_DIV: c = 8'h02;
            K_JR, K_J: c = 8'h80;
            K_JAL: c = 8'h82;
            K_LW: c = 8'h2E;
            K_SW: c = 8'h14;
            K_BEQ, K_BNE: c = 8'h40;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] alu_op_of(input kind_t k);
        logic [1:0] a;
        a = 2'd0;
        unique case (k)
            K_ADD, K_SUB, K_SLL, K_SRL, K_MUL, K_ADDI: a = 2'd2;
            K_OR, K_BEQ, K_BNE: a = 2'd1;
            K_NOR, K_SLT, K_MULT, K_DIV: a = 2'd3;
            default: a = 2'd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/mips_subset_decode_execute.sv
// ----------------------------------------------------------------------------
// mips_subset_decode_execute
// Decodes and executes one MIPS subset instruction against a register file.
// ----------------------------------------------------------------------------
// steps from request to result: decode, read rs, read rt, execute;
//   mult adds a pass through the product register, div waits on the serial divider
// a new instruction is taken only after the last one has retired; the
//   two reads share the single read port of the register file RAM
// reset: a clearing pass zeroes the register file; no request is
//   taken during it. PC resets to 256, HI and LO to zero
module mips_subset_decode_execute (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // instruction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // instr_kind, control_bits, alu_op,
                                   // result_value, write_enable, dest_reg,
                                   // next_pc, zero_flag, overflow_flag
);
    import msde_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_RDA   = 8'b0000_0100,
        ST_RDB   = 8'b0000_1000,
        ST_EXEC  = 8'b0001_0000,
        ST_MULT  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [4:0]      clr_reg, clr_next;
    logic [31:0]     pc_reg, pc_next;
    logic [31:0]     hi_reg, hi_next;
    logic [31:0]     lo_reg, lo_next;
    logic [31:0]     instr_reg;
    logic [31:0]     a_reg;
    logic [31:0]     b_reg;
    logic [31:0]     b_op;
    logic [63:0]     prod_reg;
    logic            out_valid_reg, out_valid_next;
    logic [87:0]     out_reg, out_next;
    decoded_t        dec;

    logic            rf_we;
    logic [4:0]      rf_waddr;
    logic [31:0]     rf_wdata;
    logic [4:0]      rf_raddr;
    logic [31:0]     rf_rdata;

    logic            div_start, div_done;
    logic [31:0]     div_q, div_r;

    msde_decode u_decode (
        .instruction (instr_reg),
        .dec         (dec)
    );

    msde_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_regfile (
        .aclk    (aclk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_addr (rf_raddr),
        .rd_data (rf_rdata)
    );

    msde_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_op),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // register-file read address: rs then rt; r0 handled at capture
    assign rf_raddr = (state_reg == ST_RDA) ? dec.rs : dec.rt;

    // rt operand straight from the read port during execute, held afterwards
    assign b_op = (state_reg == ST_EXEC) ? ((dec.rt == 5'd0) ? 32'd0 : rf_rdata) : b_reg;

    // execute datapath
    logic [31:0] pc4, res, npc, imm_sh, sum_ab, dif_ab, sum_ai;
    logic [62:0] sll_wide;
    logic [4:0]  dest;
    logic        we, ovf, finish;
    logic [63:0] mprod;

    assign pc4      = pc_reg + 32'd4;
    assign imm_sh   = {dec.imm[29:0], 2'b00};
    assign sum_ab   = a_reg + b_op;
    assign dif_ab   = a_reg - b_op;
    assign sum_ai   = a_reg + dec.imm;
    assign sll_wide = {31'd0, b_op} << dec.shamt;
    assign mprod    = prod_reg;

    always_comb begin
        res    = 32'd0;
        npc    = pc4;
        dest   = 5'd0;
        we     = 1'b0;
        ovf    = 1'b0;
        hi_next = hi_reg;
        lo_next = lo_reg;
        unique case (dec.kind)
            K_ADD: begin
                res = sum_ab; ovf = (a_reg[31] ~^ b_op[31]) & (a_reg[31] ^ res[31]);
                dest = dec.rd; we = !ovf;
            end
            K_SUB: begin
                res = dif_ab; ovf = (a_reg[31] ^ b_op[31]) & (a_reg[31] ^ res[31]);
                dest = dec.rd; we = !ovf;
            end
            K_ADDI: begin
                res = sum_ai; ovf = (a_reg[31] ~^ dec.imm[31]) & (a_reg[31] ^ res[31]);
                dest = dec.rt; we = !ovf;
            end
            K_AND: begin res = a_reg & b_op; dest = dec.rd; we = 1'b1; end
            K_OR:  begin res = a_reg | b_op; dest = dec.rd; we = 1'b1; end
            K_NOR: begin res = ~(a_reg | b_op); dest = dec.rd; we = 1'b1; end
            K_SLT: begin
                res = {31'd0, ($signed(a_reg) < $signed(b_op))};
                dest = dec.rd; we = 1'b1;
            end
            K_SLL: begin
                res = sll_wide[31:0]; ovf = |sll_wide[62:31];
                dest = dec.rd; we = 1'b1;
            end
            K_SRL: begin res = b_op >> dec.shamt; dest = dec.rd; we = 1'b1; end
            K_MULT: begin
                hi_next = mprod[63:32]; lo_next = mprod[31:0]; res = mprod[31:0];
            end
            K_MUL: begin
                res = mprod[31:0];
                ovf = (mprod[63:31] != {33{1'b0}}) && (mprod[63:31] != {33{1'b1}});
                dest = dec.rd; we = 1'b1;
            end
            K_DIV: begin
                if (b_op == 32'd0) begin
                    ovf = 1'b1;
                end else begin
                    ovf = (a_reg == 32'h8000_0000) && (b_op == 32'hFFFF_FFFF);
                    if (ovf) begin
                        lo_next = 32'h8000_0000; hi_next = 32'd0;
                    end else begin
                        lo_next = div_q; hi_next = div_r;
                    end
                    res = lo_next;
                end
            end
            K_JR:  begin npc = a_reg; res = a_reg; end
            K_J:   begin npc = {pc4[31:28], dec.target, 2'b00}; res = npc; end
            K_JAL: begin
                npc = {pc4[31:28], dec.target, 2'b00}; res = pc4;
                dest = 5'd31; we = 1'b1;
            end
            K_LW:  begin res = sum_ai; dest = dec.rt; end
            K_SW:  begin res = sum_ai; end
            K_BEQ: begin res = dif_ab; if (a_reg == b_op) npc = pc4 + imm_sh; end
            K_BNE: begin res = dif_ab; if (a_reg != b_op) npc = pc4 + imm_sh; end
            default: begin end
        endcase
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        finish         = 1'b0;
        rf_we          = 1'b0;
        rf_waddr       = dest;
        rf_wdata       = res;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                rf_we    = 1'b1;
                rf_waddr = clr_reg;
                rf_wdata = 32'd0;
                clr_next = clr_reg + 5'd1;
                if (clr_reg == 5'd31) state_next = ST_IDLE;
            end
            ST_IDLE:  if (s_tvalid) state_next = ST_RDA;
            ST_RDA:   state_next = ST_RDB;
            ST_RDB:   state_next = ST_EXEC;
            ST_EXEC: begin
                if (dec.kind == K_MULT || dec.kind == K_MUL) begin
                    state_next = ST_MULT;
                end else if (dec.kind == K_DIV && b_op != 32'd0) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    finish = 1'b1;
                end
            end
            ST_MULT: finish = 1'b1;
            ST_DIV:  if (div_done) finish = 1'b1;
            ST_OUT:  if (!out_valid_reg || m_tready) finish = 1'b1;
            default: state_next = ST_IDLE;
        endcase
        // retire into the output register when it is free
        if (finish) begin
            if (out_valid_reg && !m_tready) begin
                state_next = ST_OUT;
            end else begin
                rf_we          = we && (dest != 5'd0);
                pc_next        = npc;
                out_valid_next = 1'b1;
                out_next = {1'b0, ovf, (dec.kind != K_UNKNOWN) && (res == 32'd0), npc,
                            dest, we, res, alu_op_of(dec.kind), ctl_bits(dec.kind),
                            dec.kind};
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= 5'd0;
            pc_reg        <= RESET_PC;
            hi_reg        <= 32'd0;
            lo_reg        <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (finish && !(out_valid_reg && !m_tready)) begin
                hi_reg <= hi_next;
                lo_reg <= lo_next;
            end
        end
        out_reg <= out_next;
        // payload capture
        if (state_reg == ST_IDLE && s_tvalid) instr_reg <= s_tdata;
        if (state_reg == ST_RDB) a_reg <= (dec.rs == 5'd0) ? 32'd0 : rf_rdata;
        if (state_reg == ST_EXEC) begin
            b_reg    <= b_op;
            prod_reg <= 64'($signed(a_reg) * $signed(b_op));
        end
    end

endmodule

>>> rtl/core/msde_ram.sv
// ----------------------------------------------------------------------------
// msde_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module msde_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/msde_decode.sv
// ----------------------------------------------------------------------------
// msde_decode
// Splits an instruction word into fields and classifies its kind.
// ----------------------------------------------------------------------------
module msde_decode (
    input  logic [31:0]        instruction,
    output msde_pkg::decoded_t dec
);
    import msde_pkg::*;

    logic [5:0] op;
    logic [5:0] fn;
    kind_t      kind;

    assign op = instruction[31:26];
    assign fn = instruction[5:0];

    // kind classification
    always_comb begin
        kind = K_UNKNOWN;
        unique case (op)
            OP_SPEC2: kind = (fn == FN_MUL) ? K_MUL : K_UNKNOWN;
            OP_RTYPE: begin
                unique case (fn)
                    FN_ADD:  kind = K_ADD;
                    FN_SUB:  kind = K_SUB;
                    FN_AND:  kind = K_AND;
                    FN_OR:   kind = K_OR;
                    FN_NOR:  kind = K_NOR;
                    FN_SLT:  kind = K_SLT;
                    FN_SLL:  kind = K_SLL;
                    FN_SRL:  kind = K_SRL;
                    FN_MULT: kind = K_MULT;
                    FN_DIV:  kind = K_DIV;
                    FN_JR:   kind = K_JR;
                    default: kind = K_UNKNOWN;
                endcase
            end
            OP_J:    kind = K_J;
            OP_JAL:  kind = K_JAL;
            OP_ADDI: kind = K_ADDI;
            OP_LW:   kind = K_LW;
            OP_SW:   kind = K_SW;
            OP_BEQ:  kind = K_BEQ;
            OP_BNE:  kind = K_BNE;
            default: kind = K_UNKNOWN;
        endcase
    end

    // field split with sign-extended immediate
    always_comb begin
        dec.kind   = kind;
        dec.rs     = instruction[25:21];
        dec.rt     = instruction[20:16];
        dec.rd     = instruction[15:11];
        dec.shamt  = instruction[10:6];
        dec.imm    = {{16{instruction[15]}}, instruction[15:0]};
        dec.target = instruction[25:0];
    end

endmodule

>>> rtl/core/msde_divider.sv
// ----------------------------------------------------------------------------
// msde_divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msde_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    import msde_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  count_reg, count_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        qneg_reg, qneg_next;
    logic        rneg_reg, rneg_next;
    logic [32:0] trial;

    assign trial = {rem_reg[31:0], quo_reg[31]} - {1'b0, dsr_reg};

    // iteration control
    always_comb begin
        busy_next  = busy_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        qneg_next  = qneg_reg;
        rneg_next  = rneg_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = 6'd0;
            quo_next   = dividend[31] ? (32'd0 - dividend) : dividend;
            dsr_next   = divisor[31] ? (32'd0 - divisor) : divisor;
            rem_next   = 33'd0;
            qneg_next  = dividend[31] ^ divisor[31];
            rneg_next  = dividend[31];
        end else if (busy_reg) begin
            if (trial[32]) begin
                rem_next = {rem_reg[31:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            count_next = count_reg + 6'd1;
            if (count_reg == 6'd31) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= 6'd0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    // sign fix-up of the magnitudes
    assign done      = !busy_reg && (count_reg == 6'd32);
    assign quotient  = qneg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign remainder = rneg_reg ? (32'd0 - rem_reg[31:0]) : rem_reg[31:0];

endmodule

>>> sim/mips_subset_decode_execute_test.sv
// ----------------------------------------------------------------------------
// mips_subset_decode_execute_test
// Streams MIPS subset instruction words into the decoder, predicts each
// decoded and executed result with a local model of the register file,
// HI/LO and PC, and compares every result field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_subset_decode_execute_test;
    import msde_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic        ovf;
        logic        zero;
        logic [31:0] npc;
        logic [4:0]  dest;
        logic        we;
        logic [31:0] res;
        logic [1:0]  aluop;
        logic [7:0]  ctl;
        logic [4:0]  kind;
    } exec_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;

    // predictor state
    logic [31:0] pc_q;
    logic [31:0] regs_q [32];
    logic [31:0] hi_q;
    logic [31:0] lo_q;

    exec_result_t expected_results [$];
    int unsigned  fail_count;
    int unsigned  cycle_count;
    bit           quiet_mode;
    bit           rx_hold;

    mips_subset_decode_execute DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] rd_reg(input logic [4:0] n);
        return (n == 5'd0) ? 32'd0 : regs_q[n];
    endfunction

    function automatic kind_t decode_kind(input logic [31:0] ins);
        logic [5:0] op;
        logic [5:0] fn;
        op = ins[31:26];
        fn = ins[5:0];
        if (op == OP_SPEC2) return (fn == FN_MUL) ? K_MUL : K_UNKNOWN;
        if (op == OP_RTYPE) begin
            case (fn)
                FN_ADD: return K_ADD;
                FN_SUB: return K_SUB;
                FN_AND: return K_AND;
                FN_OR: return K_OR;
                FN_NOR: return K_NOR;
                FN_SLT: return K_SLT;
                FN_SLL: return K_SLL;
                FN_SRL: return K_SRL;
                FN_MULT: return K_MULT;
                FN_DIV: return K_DIV;
                FN_JR: return K_JR;
                default: return K_UNKNOWN;
            endcase
        end
        case (op)
            OP_J: return K_J;
            OP_JAL: return K_JAL;
            OP_ADDI: return K_ADDI;
            OP_LW: return K_LW;
            OP_SW: return K_SW;
            OP_BEQ: return K_BEQ;
            OP_BNE: return K_BNE;
            default: return K_UNKNOWN;
        endcase
    endfunction

    // execute one instruction on the local state and return its result
    function automatic exec_result_t execute_instr(input logic [31:0] ins);
        exec_result_t r;
        kind_t        k;
        logic [31:0]  a, b, imm, res, pc4, npc, tgt;
        logic [4:0]   dest;
        logic         we, ovf;
        logic signed [63:0] prod;
        logic [63:0]  sh64;
        k = decode_kind(ins);
        imm = {{16{ins[15]}}, ins[15:0]};
        a = rd_reg(ins[25:21]);
        b = rd_reg(ins[20:16]);
        pc4 = pc_q + 32'd4;
        npc = pc4;
        tgt = {pc4[31:28], ins[25:0], 2'b00};
        res = '0;
        dest = '0;
        we = 1'b0;
        ovf = 1'b0;
        case (k)
            K_ADD: begin
                res = a + b; ovf = (a[31] == b[31]) && (res[31] != a[31]);
                dest = ins[15:11]; we = !ovf;
            end
            K_SUB: begin
                res = a - b; ovf = (a[31] != b[31]) && (res[31] != a[31]);
                dest = ins[15:11]; we = !ovf;
            end
            K_ADDI: begin
                res = a + imm; ovf = (a[31] == imm[31]) && (res[31] != a[31]);
                dest = ins[20:16]; we = !ovf;
            end
            K_AND: begin res = a & b; dest = ins[15:11]; we = 1'b1; end
            K_OR: begin res = a | b; dest = ins[15:11]; we = 1'b1; end
            K_NOR: begin res = ~(a | b); dest = ins[15:11]; we = 1'b1; end
            K_SLT: begin
                res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                dest = ins[15:11]; we = 1'b1;
            end
            K_SLL: begin
                sh64 = {32'd0, b} << ins[10:6];
                res = sh64[31:0]; ovf = |sh64[63:31];
                dest = ins[15:11]; we = 1'b1;
            end
            K_SRL: begin res = b >> ins[10:6]; dest = ins[15:11]; we = 1'b1; end
            K_MULT: begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                hi_q = prod[63:32]; lo_q = prod[31:0]; res = lo_q;
            end
            K_MUL: begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                res = prod[31:0];
                ovf = (prod[63:31] != '0) && (prod[63:31] != '1);
                dest = ins[15:11]; we = 1'b1;
            end
            K_DIV: begin
                if (b == 32'd0) begin
                    ovf = 1'b1;
                end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                    ovf = 1'b1; lo_q = 32'h8000_0000; hi_q = 32'd0; res = lo_q;
                end else begin
                    lo_q = $signed(a) / $signed(b);
                    hi_q = $signed(a) % $signed(b);
                    res = lo_q;
                end
            end
            K_JR: begin npc = a; res = a; end
            K_J: begin npc = tgt; res = tgt; end
            K_JAL: begin npc = tgt; res = pc4; dest = 5'd31; we = 1'b1; end
            K_LW: begin res = a + imm; dest = ins[20:16]; end
            K_SW: res = a + imm;
            K_BEQ: begin res = a - b; if (a == b) npc = pc4 + (imm << 2); end
            K_BNE: begin res = a - b; if (a != b) npc = pc4 + (imm << 2); end
            default: ;
        endcase
        if (we && dest != 5'd0) regs_q[dest] = res;
        pc_q = npc;
        r.kind = k;
        r.ctl = ctl_bits(k);
        r.aluop = alu_op_of(k);
        r.res = res;
        r.we = we;
        r.dest = dest;
        r.npc = npc;
        r.zero = (k != K_UNKNOWN) && (res == 32'd0);
        r.ovf = ovf;
        return r;
    endfunction

    // send one request, with random idle cycles unless in a quiet stretch
    task automatic send_instr(input logic [31:0] ins);
        while (!quiet_mode && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ins;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(execute_instr(ins));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [4:0] rd,
                                           input logic [4:0] sh);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] im);
        return {op, rs, rt, im};
    endfunction

    // extremes, every kind and the named corner cases
    task automatic test_directed();
        send_instr(i_word(OP_ADDI, 5'd0, 5'd1, 16'h7FFF));
        send_instr(i_word(OP_ADDI, 5'd0, 5'd2, 16'h8000));
        send_instr(r_word(FN_SLL, 5'd0, 5'd1, 5'd3, 5'd16));       // 0x7fff0000
        send_instr(r_word(FN_ADD, 5'd3, 5'd3, 5'd4, 5'd0));        // overflow, no write
        send_instr(r_word(FN_SUB, 5'd2, 5'd3, 5'd5, 5'd7));
        send_instr(r_word(FN_AND, 5'd1, 5'd2, 5'd6, 5'd0));
        send_instr(r_word(FN_OR, 5'd1, 5'd2, 5'd7, 5'd0));
        send_instr(r_word(FN_NOR, 5'd0, 5'd0, 5'd8, 5'd0));       // all ones
        send_instr(r_word(FN_SLT, 5'd2, 5'd1, 5'd0, 5'd0));       // write to r0
        send_instr(r_word(FN_SLL, 5'd0, 5'd8, 5'd9, 5'd31));
        send_instr(r_word(FN_SRL, 5'd0, 5'd8, 5'd10, 5'd31));
        send_instr(r_word(FN_MULT, 5'd8, 5'd3, 5'd0, 5'd0));
        send_instr({OP_SPEC2, 5'd3, 5'd3, 5'd11, 5'd0, FN_MUL});
        send_instr(r_word(FN_DIV, 5'd3, 5'd0, 5'd0, 5'd0));       // divide by zero
        send_instr(r_word(FN_SLL, 5'd0, 5'd1, 5'd12, 5'd31));     // most negative
        send_instr(r_word(FN_DIV, 5'd12, 5'd8, 5'd0, 5'd0));
        send_instr(r_word(FN_DIV, 5'd3, 5'd2, 5'd0, 5'd5));
        send_instr(i_word(OP_LW, 5'd1, 5'd13, 16'hFFFC));
        send_instr(i_word(OP_SW, 5'd2, 5'd13, 16'h0004));
        send_instr(i_word(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
        send_instr(i_word(OP_BNE, 5'd1, 5'd2, 16'h7FFF));
        send_instr({OP_JAL, 26'h3FF_FFFF});
        send_instr({OP_J, 26'h000_0000});
        send_instr(r_word(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0));
        send_instr(32'hFFFF_FFFF);                                 // unknown
        drain_results();
    endtask

    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [5:0]  fns [11];
        logic [5:0]  ops [7];
        int unsigned pick;
        fns = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLL, FN_SRL,
                FN_MULT, FN_DIV, FN_JR};
        ops = '{OP_J, OP_JAL, OP_ADDI, OP_LW, OP_SW, OP_BEQ, OP_BNE};
        w = $urandom();
        pick = $urandom_range(99);
        if (pick < 50) begin
            w[31:26] = OP_RTYPE; w[5:0] = fns[$urandom_range(10)];
        end else if (pick < 55) begin
            w[31:26] = OP_SPEC2; w[5:0] = FN_MUL;
        end else if (pick < 92) begin
            w[31:26] = ops[$urandom_range(6)];
        end
        // jr is drawn as often as any other R-type function code
        return w;
    endfunction

    task automatic test_random(input int unsigned n);
        repeat (n) send_instr(random_instr());
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        rx_hold = 1'b1;
        repeat (30) send_instr(random_instr());
        drain_results();
    endtask

    // no idling on either side
    task automatic test_no_idle();
        quiet_mode = 1'b1;
        repeat (120) send_instr(random_instr());
        drain_results();
        quiet_mode = 1'b0;
    endtask

    // receiver: random stalls, long hold when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                rx_hold = 1'b0;
            end
            m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    // result checker
    always @(posedge aclk) begin
        exec_result_t got;
        exec_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = exec_result_t'(m_tdata[86:0]);
            if (expected_results.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.kind != exp_r.kind) begin
                    $error("instr_kind exp %0d got %0d", exp_r.kind, got.kind); fail_count++;
                end
                if (got.ctl != exp_r.ctl) begin
                    $error("control_bits exp %h got %h", exp_r.ctl, got.ctl); fail_count++;
                end
                if (got.aluop != exp_r.aluop) begin
                    $error("alu_op exp %0d got %0d", exp_r.aluop, got.aluop); fail_count++;
                end
                if (got.res != exp_r.res) begin
                    $error("result_value exp %h got %h", exp_r.res, got.res); fail_count++;
                end
                if (got.we != exp_r.we) begin
                    $error("write_enable exp %b got %b", exp_r.we, got.we); fail_count++;
                end
                if (got.dest != exp_r.dest) begin
                    $error("dest_reg exp %0d got %0d", exp_r.dest, got.dest); fail_count++;
                end
                if (got.npc != exp_r.npc) begin
                    $error("next_pc exp %h got %h", exp_r.npc, got.npc); fail_count++;
                end
                if (got.zero != exp_r.zero) begin
                    $error("zero_flag exp %b got %b", exp_r.zero, got.zero); fail_count++;
                end
                if (got.ovf != exp_r.ovf) begin
                    $error("overflow_flag exp %b got %b", exp_r.ovf, got.ovf); fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // test sequence
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        fail_count = 0;
        cycle_count = 0;
        quiet_mode = 1'b0;
        rx_hold = 1'b0;
        pc_q = RESET_PC;
        for (int i = 0; i < 32; i++) regs_q[i] = '0;
        hi_q = '0;
        lo_q = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(250);
        test_no_idle();
        test_random(150);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
